// ===== hdl/b2da_pkg.sv =====
// Shared types and constants for the binary to decimal ASCII converter.
package b2da_pkg;

	localparam int VALUE_W    = 32;
	localparam int NUM_DIGITS = 10;
	localparam int DIGIT_W    = 4;
	localparam int IDX_W      = 4;
	localparam int CNT_W      = 4;
	localparam int CHAR_W     = 6;
	localparam int TDATA_W    = 16;

	localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(NUM_DIGITS - 1);
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

	// Data handed from cell to cell: running remainder, digits found so far
	// (indexed by decimal place, most significant first) and significant digit count.
	typedef struct packed {
		logic [VALUE_W-1:0]                   rem;
		logic [NUM_DIGITS-1:0][DIGIT_W-1:0]   digits;
		logic [CNT_W-1:0]                     count;
	} stage_t;

	// Place value for each cell, 10^9 down to 10^0.
	function automatic logic [VALUE_W-1:0] place_value(input logic [IDX_W-1:0] idx);
		logic [VALUE_W-1:0] v;
		case (idx)
			4'd0:    v = 32'd1000000000;
			4'd1:    v = 32'd100000000;
			4'd2:    v = 32'd10000000;
			4'd3:    v = 32'd1000000;
			4'd4:    v = 32'd100000;
			4'd5:    v = 32'd10000;
			4'd6:    v = 32'd1000;
			4'd7:    v = 32'd100;
			4'd8:    v = 32'd10;
			default: v = 32'd1;
		endcase
		return v;
	endfunction

endpackage

// ===== hdl/binary_to_decimal_ascii_top.sv =====
// Binary to decimal ASCII converter, top level.
// Each 32-bit unsigned value taken on the slave stream leaves the master stream as its
// decimal digits in ASCII, most significant first, leading zeros dropped (zero gives a
// single '0'); every transaction carries the run's digit count and tlast marks the final
// digit. The value passes a row of ten cells, one per power of ten from 10^9 down to 1.
// The row accepts a new value every cycle while it has room; sustained throughput is set
// by the output stage, which sends one digit per cycle while m_tready is high and takes
// the next value as it sends the last digit of a run of 1..10 digits.
module binary_to_decimal_ascii_top
	import b2da_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [VALUE_W-1:0] s_tdata,   // [31:0] value
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // [5:0] digit_char, [9:6] digit_count, [15:10] zero
	output logic               m_tlast    // last_digit
);

	stage_t               chain_data  [NUM_DIGITS+1];
	logic [NUM_DIGITS:0]  chain_valid;
	logic [NUM_DIGITS:0]  chain_ready;

	assign chain_valid[0]       = s_tvalid;
	assign s_tready             = chain_ready[0];
	assign chain_data[0].rem    = s_tdata;
	assign chain_data[0].digits = '0;
	assign chain_data[0].count  = '0;

	for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
		b2da_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.place_idx (IDX_W'(i)),
			.in_valid  (chain_valid[i]),
			.in_ready  (chain_ready[i]),
			.in_data   (chain_data[i]),
			.out_valid (chain_valid[i+1]),
			.out_ready (chain_ready[i+1]),
			.out_data  (chain_data[i+1])
		);
	end

	b2da_serializer u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chain_valid[NUM_DIGITS]),
		.in_ready (chain_ready[NUM_DIGITS]),
		.in_data  (chain_data[NUM_DIGITS]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== hdl/b2da_cell.sv =====
// One conversion cell: extracts the digit of one decimal place and passes the remainder on.
module b2da_cell
	import b2da_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] place_idx,
	input  logic             in_valid,
	output logic             in_ready,
	input  stage_t           in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output stage_t           out_data
);

	logic   valid_q;
	stage_t data_q;
	stage_t next_data;

	always_comb begin
		logic [VALUE_W+3:0] wide_rem;
		logic [VALUE_W+3:0] mult;
		logic [VALUE_W-1:0] place;
		logic [VALUE_W-1:0] sub;
		logic [DIGIT_W-1:0] d;
		place    = place_value(place_idx);
		wide_rem = {4'b0, in_data.rem};
		d        = '0;
		sub      = '0;
		mult     = '0;
		// compares against 1x..9x place are monotone; highest match wins
		for (int k = 1; k <= 9; k++) begin
			mult = (VALUE_W+4)'(k) * {4'b0, place};
			if (wide_rem >= mult) begin
				d   = DIGIT_W'(k);
				sub = mult[VALUE_W-1:0];
			end
		end
		next_data                   = in_data;
		next_data.rem               = in_data.rem - sub;
		next_data.digits[place_idx] = d;
		if (d != '0 || in_data.count != '0) begin
			next_data.count = in_data.count + 1'b1;
		end
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= next_data;
		end
	end

endmodule

// ===== hdl/b2da_serializer.sv =====
// Output stage: sends the significant digits of one conversion as ASCII, one per transaction.
module b2da_serializer
	import b2da_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  stage_t             in_data,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,
	output logic               m_tlast
);

	logic                               busy_q;
	logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_q;
	logic [CNT_W-1:0]                   cnt_q;
	logic [IDX_W-1:0]                   idx_q;
	logic [CNT_W-1:0]                   cnt_fix;
	logic                               at_last;
	logic                               load;
	logic [CHAR_W-1:0]                  char_code;

	assign at_last  = idx_q == LAST_IDX;
	assign in_ready = !busy_q || (m_tready && at_last);
	assign load     = in_valid && in_ready;
	// zero input has no significant digit; emit the units digit alone
	assign cnt_fix  = (in_data.count == '0) ? CNT_W'(1) : in_data.count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (load) begin
			busy_q <= 1'b1;
		end else if (m_tready && at_last) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			digits_q <= in_data.digits;
			cnt_q    <= cnt_fix;
			idx_q    <= IDX_W'(NUM_DIGITS) - IDX_W'(cnt_fix);
		end else if (busy_q && m_tready && !at_last) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	assign char_code = ASCII_ZERO + CHAR_W'(digits_q[idx_q]);
	assign m_tvalid  = busy_q;
	assign m_tlast   = at_last;
	assign m_tdata   = {(TDATA_W-CHAR_W-CNT_W)'(0), cnt_q, char_code};

endmodule

// ===== hdl/b2da_checker.sv =====
// Port-level checks for the binary to decimal ASCII converter, bound to the top level.
module b2da_checker
	import b2da_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [TDATA_W-1:0] m_tdata,
	input logic               m_tlast
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("m_tvalid dropped while stalled");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[5:0] >= 6'd48 && m_tdata[5:0] <= 6'd57))
		else $error("digit_char not a decimal digit");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[9:6] >= 4'd1 && m_tdata[9:6] <= 4'd10))
		else $error("digit_count out of range");

	// a run continues without a gap and keeps its count
	a_run_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=>
			m_tvalid && m_tdata[9:6] == $past(m_tdata[9:6]))
		else $error("run broken or digit_count changed mid-run");

endmodule

bind binary_to_decimal_ascii_top b2da_checker u_b2da_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// ===== sim/tb.sv =====
// Self-checking testbench for the binary to decimal ASCII converter top level.
module tb;
	import b2da_pkg::*;

	typedef struct {
		logic [CHAR_W-1:0] digit_char;
		logic              last_digit;
		logic [CNT_W-1:0]  digit_count;
	} ascii_digit_t;

	localparam int DIR_N = 19;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [VALUE_W-1:0] s_tdata  = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic               m_tlast;

	ascii_digit_t digits_pending [$];
	ascii_digit_t want;
	int           error_count    = 0;
	int           sender_idle_pct = 0;
	int           recv_stall_pct  = 0;

	logic [VALUE_W-1:0] dir_value [DIR_N];
	string              dir_text  [DIR_N];

	binary_to_decimal_ascii_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Repeated subtraction of each power of ten, leading zeros dropped.
	function automatic void predict_decimal_digits(input logic [VALUE_W-1:0] value);
		logic [VALUE_W-1:0] rest;
		logic [VALUE_W-1:0] place;
		logic [DIGIT_W-1:0] digit;
		logic [DIGIT_W-1:0] found [NUM_DIGITS];
		int                 n;
		rest  = value;
		place = 32'd1000000000;
		n     = 0;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			digit = '0;
			while (digit < 9 && rest >= place) begin
				rest  = rest - place;
				digit = digit + 1'b1;
			end
			if (digit != 0 || n > 0) begin
				found[n] = digit;
				n++;
			end
			place = place / 10;
		end
		if (n == 0) begin
			found[0] = '0;
			n = 1;
		end
		for (int i = 0; i < n; i++)
			digits_pending.push_back('{digit_char: ASCII_ZERO + CHAR_W'(found[i]),
				last_digit: (i == n - 1), digit_count: CNT_W'(n)});
	endfunction

	// Expected run typed in as the decimal string itself.
	function automatic void queue_text_digits(input string text);
		for (int i = 0; i < text.len(); i++)
			digits_pending.push_back('{digit_char: CHAR_W'(text[i]),
				last_digit: (i == text.len() - 1), digit_count: CNT_W'(text.len())});
	endfunction

	// Digit length picked first so short and long runs both show up often.
	function automatic logic [VALUE_W-1:0] random_value();
		int          len;
		logic [31:0] lo;
		logic [31:0] hi;
		len = $urandom_range(11, 1);
		if (len == 11)
			return $urandom();
		if (len == 10)
			return $urandom_range(32'hFFFF_FFFF, 32'd1000000000);
		lo = 1;
		for (int i = 1; i < len; i++)
			lo = lo * 10;
		hi = lo * 10 - 1;
		if (len == 1)
			lo = 0;
		return $urandom_range(hi, lo);
	endfunction

	task automatic send_value(input logic [VALUE_W-1:0] value, input string text);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (text.len() != 0)
			queue_text_digits(text);
		else
			predict_decimal_digits(value);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (digits_pending.size() == 0) begin
				$error("unexpected digit transaction, tdata %h", m_tdata);
				error_count++;
			end else begin
				want = digits_pending.pop_front();
				if (m_tdata[CHAR_W-1:0] !== want.digit_char) begin
					$error("digit_char expected %0d, got %0d", want.digit_char,
						m_tdata[CHAR_W-1:0]);
					error_count++;
				end
				if (m_tlast !== want.last_digit) begin
					$error("last_digit expected %0d, got %0d", want.last_digit, m_tlast);
					error_count++;
				end
				if (m_tdata[CHAR_W+CNT_W-1:CHAR_W] !== want.digit_count) begin
					$error("digit_count expected %0d, got %0d", want.digit_count,
						m_tdata[CHAR_W+CNT_W-1:CHAR_W]);
					error_count++;
				end
			end
		end
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		dir_value = '{32'd0, 32'd9, 32'hFFFF_FFFF, 32'd1000000000, 32'd10, 32'd100,
			32'd1, 32'd99, 32'd999999999, 32'd4000000000, 32'd123456789,
			32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFE, 32'd1001,
			32'd19, 32'd909090909, 32'd3999999999};
		dir_text = '{"0", "9", "4294967295", "1000000000", "10", "100",
			"", "", "", "", "", "", "", "", "", "", "", "", ""};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin sender_idle_pct = 78; recv_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  recv_stall_pct = 78; end
				default: begin sender_idle_pct = 12; recv_stall_pct = 12; end
			endcase
			if (phase == 0)
				for (int r = 0; r < DIR_N; r++)
					send_value(dir_value[r], dir_text[r]);
			for (int k = 0; k < 53; k++)
				send_value(random_value(), "");
			// drain completely before the next phase
			s_tvalid <= 1'b0;
			while (digits_pending.size() != 0)
				@(posedge clk);
		end

		repeat (30) @(posedge clk);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#400000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
